// ----- rtl/cfv_pkg.sv -----
`timescale 1ns / 1ps
package cfv_pkg;

  // Table depth and the widths that follow from it.
  localparam int MAX_NODES = 16;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = $clog2(MAX_NODES + 1);

  // Fixed field widths.
  localparam int CMD_W = 2;
  localparam int ID_W  = 8;
  localparam int TOT_W = 5;
  localparam int POS_W = 32;
  localparam int CMP_W = (CNT_W > TOT_W) ? CNT_W : TOT_W;

  // Datapath widths: a difference of two positions, a term of the sum,
  // and the sum over all table entries.
  localparam int DIF_W = POS_W + 1;
  localparam int TRM_W = POS_W + 2;
  localparam int ACC_W = TRM_W + IDX_W;

  // Configuration port.
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_OWN_ID     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NODE_TOTAL = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LEAD_ID    = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ANNOUNCE = 2'd0,
    CMD_REPORT   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [ID_W-1:0]  own_id;
    logic [TOT_W-1:0] node_total;
    logic [ID_W-1:0]  lead_id;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]        rd_addr;
    logic                    ann_we;
    logic [IDX_W-1:0]        ann_addr;
    logic                    lat_we;
    logic [IDX_W-1:0]        lat_addr;
    logic                    lat_clr;
    logic [ID_W-1:0]         wr_id;
    logic signed [POS_W-1:0] wr_x;
    logic signed [POS_W-1:0] wr_y;
  } tbl_ctl_t;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] fx;
    logic signed [POS_W-1:0] fy;
    logic signed [POS_W-1:0] lx;
    logic signed [POS_W-1:0] ly;
  } tbl_rd_t;

  typedef struct packed {
    logic                    start;
    logic                    add;
    logic signed [POS_W-1:0] own_x;
    logic signed [POS_W-1:0] own_y;
    logic signed [POS_W-1:0] ref_x;
    logic signed [POS_W-1:0] ref_y;
  } acc_ctl_t;

  typedef struct packed {
    logic                    load;
    logic                    use_acc;
    logic                    full;
    logic                    ready;
    logic signed [POS_W-1:0] yaw;
  } res_t;

endpackage

// ----- rtl/cfv_regs.sv -----
`timescale 1ns / 1ps
module cfv_regs import cfv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;
  logic [ID_W-1:0]      own_id;
  logic [TOT_W-1:0]     node_total;
  logic [ID_W-1:0]      lead_id;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_id     <= ID_W'(1);
      node_total <= TOT_W'(1);
      lead_id    <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OWN_ID:     own_id     <= pwdata[ID_W-1:0];
        REG_NODE_TOTAL: node_total <= pwdata[TOT_W-1:0];
        REG_LEAD_ID:    lead_id    <= pwdata[ID_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OWN_ID:     prdata = APB_DW'(own_id);
      REG_NODE_TOTAL: prdata = APB_DW'(node_total);
      REG_LEAD_ID:    prdata = APB_DW'(lead_id);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.own_id     = own_id;
    cfg.node_total = node_total;
    cfg.lead_id    = lead_id;
  end

endmodule

// ----- rtl/cfv_table.sv -----
`timescale 1ns / 1ps
module cfv_table import cfv_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  tbl_ctl_t ctl,
  output tbl_rd_t  rd
);

  logic [ID_W-1:0]         node_ids [MAX_NODES];
  logic signed [POS_W-1:0] form_x   [MAX_NODES];
  logic signed [POS_W-1:0] form_y   [MAX_NODES];
  logic signed [POS_W-1:0] lat_x    [MAX_NODES];
  logic signed [POS_W-1:0] lat_y    [MAX_NODES];
  logic [MAX_NODES-1:0]    lat_vld;

  logic [ID_W-1:0]         id_q;
  logic signed [POS_W-1:0] fx_q, fy_q, lx_q, ly_q;
  logic                    lv_q;

  // Storage with one write port per array and a registered read.
  always_ff @(posedge clk) begin
    if (ctl.ann_we) begin
      node_ids[ctl.ann_addr] <= ctl.wr_id;
      form_x[ctl.ann_addr]   <= ctl.wr_x;
      form_y[ctl.ann_addr]   <= ctl.wr_y;
    end
    if (ctl.lat_we) begin
      lat_x[ctl.lat_addr] <= ctl.wr_x;
      lat_y[ctl.lat_addr] <= ctl.wr_y;
    end
    id_q <= node_ids[ctl.rd_addr];
    fx_q <= form_x[ctl.rd_addr];
    fy_q <= form_y[ctl.rd_addr];
    lx_q <= lat_x[ctl.rd_addr];
    ly_q <= lat_y[ctl.rd_addr];
    lv_q <= lat_vld[ctl.rd_addr];
  end

  // A latest position that was never reported since the last build reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_vld <= '0;
    end else if (ctl.lat_clr) begin
      lat_vld <= '0;
    end else if (ctl.lat_we) begin
      lat_vld[ctl.lat_addr] <= 1'b1;
    end
  end

  always_comb begin
    rd.id = id_q;
    rd.fx = fx_q;
    rd.fy = fy_q;
    rd.lx = lv_q ? lx_q : '0;
    rd.ly = lv_q ? ly_q : '0;
  end

endmodule

// ----- rtl/cfv_accum.sv -----
`timescale 1ns / 1ps
module cfv_accum import cfv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  acc_ctl_t                ctl,
  input  logic signed [POS_W-1:0] lat_x,
  input  logic signed [POS_W-1:0] lat_y,
  input  logic signed [POS_W-1:0] form_x,
  input  logic signed [POS_W-1:0] form_y,
  output logic                    busy,
  output logic signed [POS_W-1:0] sum_x,
  output logic signed [POS_W-1:0] sum_y
);

  logic                    a_vld, b_vld;
  logic signed [DIF_W-1:0] kx, ky, ux, uy;
  logic signed [TRM_W-1:0] vx, vy;
  logic signed [ACC_W-1:0] accx, accy;

  function automatic logic signed [POS_W-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-POS_W:0] hi_bits;
    hi_bits = v[ACC_W-1:POS_W-1];
    if (hi_bits == '0 || hi_bits == '1) begin
      sat = v[POS_W-1:0];
    end else if (v[ACC_W-1]) begin
      sat = {1'b1, {(POS_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(POS_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      a_vld <= ctl.add;
      b_vld <= a_vld;
    end
  end

  // Three adder stages: latest minus formation, minus the own term, into the sum.
  always_ff @(posedge clk) begin
    ux <= {lat_x[POS_W-1], lat_x} - {form_x[POS_W-1], form_x};
    uy <= {lat_y[POS_W-1], lat_y} - {form_y[POS_W-1], form_y};
    vx <= {ux[DIF_W-1], ux} - {kx[DIF_W-1], kx};
    vy <= {uy[DIF_W-1], uy} - {ky[DIF_W-1], ky};
    if (ctl.start) begin
      kx   <= {ctl.own_x[POS_W-1], ctl.own_x} - {ctl.ref_x[POS_W-1], ctl.ref_x};
      ky   <= {ctl.own_y[POS_W-1], ctl.own_y} - {ctl.ref_y[POS_W-1], ctl.ref_y};
      accx <= '0;
      accy <= '0;
    end else if (b_vld) begin
      accx <= accx + {{(ACC_W-TRM_W){vx[TRM_W-1]}}, vx};
      accy <= accy + {{(ACC_W-TRM_W){vy[TRM_W-1]}}, vy};
    end
  end

  assign busy  = a_vld | b_vld;
  assign sum_x = sat(accx);
  assign sum_y = sat(accy);

endmodule

// ----- rtl/cfv_ctrl.sv -----
`timescale 1ns / 1ps
module cfv_ctrl import cfv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_take,
  input  cmd_t                    command,
  input  logic [ID_W-1:0]         node_id,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] yaw_in,
  input  logic                    report_valid,
  input  cfg_t                    cfg,
  input  tbl_rd_t                 rd,
  input  logic                    acc_busy,
  input  logic                    res_free,
  output logic                    busy,
  output tbl_ctl_t                tbl,
  output acc_ctl_t                acc,
  output res_t                    res
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_BUILD,
    ST_DONE
  } state_t;

  state_t                  state;
  cmd_t                    item_cmd;
  logic [ID_W-1:0]         item_id;
  logic signed [POS_W-1:0] item_x, item_y;
  logic [CNT_W-1:0]        node_count, cons_len, idx, lim, count_inc;
  logic [IDX_W-1:0]        s2_idx;
  logic                    s2_vld, found, full, use_acc, cons_valid;
  logic [ID_W-1:0]         cons_own;
  logic signed [POS_W-1:0] cons_fx, cons_fy, ref_yaw;
  logic                    scanning, issue, count_hit, inc_hit, at_max;
  logic                    scan_end, s2_member, s2_match;

  assign scanning  = (state == ST_SCAN) || (state == ST_BUILD);
  assign issue     = scanning && (idx < lim);
  assign count_inc = node_count + CNT_W'(1);
  assign count_hit = CMP_W'(node_count) == CMP_W'(cfg.node_total);
  assign inc_hit   = CMP_W'(count_inc) == CMP_W'(cfg.node_total);
  assign at_max    = node_count == CNT_W'(MAX_NODES);
  assign scan_end  = (idx == lim) && !s2_vld && !(item_cmd == CMD_TICK && acc_busy);
  assign s2_member = s2_vld && (rd.id != cons_own);
  assign s2_match  = rd.id == item_id;
  assign busy      = state != ST_IDLE;

  always_comb begin
    tbl.rd_addr  = idx[IDX_W-1:0];
    tbl.ann_we   = state == ST_APPEND;
    tbl.ann_addr = node_count[IDX_W-1:0];
    tbl.lat_we   = (state == ST_SCAN) && (item_cmd == CMD_REPORT) && s2_member && s2_match;
    tbl.lat_addr = s2_idx;
    tbl.lat_clr  = (state == ST_BUILD) && scan_end && found;
    tbl.wr_id    = item_id;
    tbl.wr_x     = item_x;
    tbl.wr_y     = item_y;
    acc.start    = item_take && (command == CMD_TICK);
    acc.add      = (state == ST_SCAN) && (item_cmd == CMD_TICK) && s2_member;
    acc.own_x    = pos_x;
    acc.own_y    = pos_y;
    acc.ref_x    = cons_fx;
    acc.ref_y    = cons_fy;
    res.load     = (state == ST_DONE) && res_free;
    res.use_acc  = use_acc;
    res.full     = full;
    res.ready    = count_hit;
    res.yaw      = ref_yaw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= '0;
      cons_valid <= 1'b0;
      cons_len   <= '0;
      cons_own   <= '0;
      ref_yaw    <= '0;
      s2_vld     <= 1'b0;
      idx        <= '0;
      lim        <= '0;
      found      <= 1'b0;
      full       <= 1'b0;
      use_acc    <= 1'b0;
    end else begin
      s2_vld <= issue;
      s2_idx <= idx[IDX_W-1:0];
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end
      case (state)
        ST_IDLE: begin
          if (item_take) begin
            item_cmd <= command;
            item_id  <= node_id;
            item_x   <= pos_x;
            item_y   <= pos_y;
            found    <= 1'b0;
            full     <= 1'b0;
            idx      <= '0;
            use_acc  <= (command == CMD_TICK) && count_hit && cons_valid;
            if ((command == CMD_REPORT) && report_valid && (node_id == cfg.lead_id)) begin
              ref_yaw <= yaw_in;
            end
            case (command)
              CMD_ANNOUNCE: begin
                lim   <= node_count;
                state <= ST_SCAN;
              end
              CMD_REPORT: begin
                lim   <= cons_len;
                state <= (report_valid && cons_valid) ? ST_SCAN : ST_DONE;
              end
              CMD_TICK: begin
                lim   <= cons_len;
                state <= (count_hit && cons_valid) ? ST_SCAN : ST_DONE;
              end
              default: begin
                lim   <= '0;
                state <= ST_DONE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (s2_vld && (item_cmd == CMD_ANNOUNCE) && s2_match) begin
            found <= 1'b1;
          end
          if (scan_end) begin
            if ((item_cmd == CMD_ANNOUNCE) && !found) begin
              if (at_max) begin
                full  <= 1'b1;
                state <= ST_DONE;
              end else begin
                state <= ST_APPEND;
              end
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_APPEND: begin
          node_count <= count_inc;
          idx        <= '0;
          lim        <= count_inc;
          found      <= 1'b0;
          state      <= inc_hit ? ST_BUILD : ST_DONE;
        end
        ST_BUILD: begin
          if (s2_vld && (rd.id == cfg.own_id) && !found) begin
            found   <= 1'b1;
            cons_fx <= rd.fx;
            cons_fy <= rd.fy;
          end
          if (scan_end) begin
            cons_valid <= found;
            if (found) begin
              cons_len <= node_count;
              cons_own <= cfg.own_id;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    node_count <= CNT_W'(MAX_NODES))
    else $error("node count beyond table depth");

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND) |-> !at_max)
    else $error("append into a full table");

  a_latest_write: assert property (@(posedge clk) disable iff (rst)
    tbl.lat_we |-> (cons_valid && (item_cmd == CMD_REPORT)))
    else $error("latest position written outside a report");

  a_read_source: assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> $past(scanning))
    else $error("table read data flagged without a scan");

endmodule

// ----- rtl/consensus_formation_velocity.sv -----
`timescale 1ns / 1ps
// Channel   Handshake                   Transfer when               Payload
// config    psel/penable/pwrite/pready  psel & penable & pready     paddr, pwdata, prdata
// item      item_valid / item_stall     item_valid & !item_stall    command .. report_valid
// result    result_valid / result_stall result_valid & !result_stall vel_x .. leader_is_self
//
// One sequencer walks the node table one entry per cycle. With n entries held and m in the
// consensus set, an announce walks all n entries, and an appended one walks them again when
// it completes the formation; a valid report once the set exists and a ready tick walk the m
// entries, the tick also waiting on the adder chain. Other items skip the walk.
// Reset is synchronous: the table starts empty and needs no clearing pass.
// A stalled result register holds the sequencer in its last state, item_stall still high.
module consensus_formation_velocity import cfv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_AW-1:0]       paddr,
  input  logic [APB_DW-1:0]       pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic [CMD_W-1:0]        command,
  input  logic [ID_W-1:0]         node_id,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] yaw_in,
  input  logic                    report_valid,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic signed [POS_W-1:0] vel_x,
  output logic signed [POS_W-1:0] vel_y,
  output logic signed [POS_W-1:0] yaw_out,
  output logic                    formation_ready,
  output logic                    table_full,
  output logic                    leader_is_self
);

  cfg_t                    cfg;
  tbl_ctl_t                tbl_ctl;
  tbl_rd_t                 tbl_rd;
  acc_ctl_t                acc_ctl;
  res_t                    res;
  logic                    busy, acc_busy, item_take, res_free;
  logic signed [POS_W-1:0] sum_x, sum_y;

  // The sequencer takes one item at a time; the result register lets it
  // finish the next item while an older result still waits downstream.
  assign item_stall = busy;
  assign item_take  = item_valid && !busy;
  assign res_free   = !result_valid || !result_stall;

  cfv_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cfv_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_take    (item_take),
    .command      (cmd_t'(command)),
    .node_id      (node_id),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .yaw_in       (yaw_in),
    .report_valid (report_valid),
    .cfg          (cfg),
    .rd           (tbl_rd),
    .acc_busy     (acc_busy),
    .res_free     (res_free),
    .busy         (busy),
    .tbl          (tbl_ctl),
    .acc          (acc_ctl),
    .res          (res)
  );

  cfv_table u_table (
    .clk (clk),
    .rst (rst),
    .ctl (tbl_ctl),
    .rd  (tbl_rd)
  );

  // The shared adder chain sums every member's term of the consensus law
  // during a tick, both axes side by side.
  cfv_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .ctl    (acc_ctl),
    .lat_x  (tbl_rd.lx),
    .lat_y  (tbl_rd.ly),
    .form_x (tbl_rd.fx),
    .form_y (tbl_rd.fy),
    .busy   (acc_busy),
    .sum_x  (sum_x),
    .sum_y  (sum_y)
  );

  // Result register. Velocity is zero unless the item was a tick while the
  // formation was ready and the own node had been found in the table.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      vel_x           <= res.use_acc ? sum_x : '0;
      vel_y           <= res.use_acc ? sum_y : '0;
      yaw_out         <= res.yaw;
      formation_ready <= res.ready;
      table_full      <= res.full;
      leader_is_self  <= cfg.lead_id == cfg.own_id;
    end
  end

endmodule
